[rtl/core/btop_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// btop_pkg
// Shared types, fixed-point constants, register indexes and the payoff
// function of the binomial tree option pricer.
// ============================================================================
package btop_pkg;

    // unsigned Q16.16 price or node value
    typedef logic [31:0] t_value;
    // unsigned Q1.30 factor, at most 2^31-1
    typedef logic [30:0] t_q30;

    localparam t_q30 Q30_ONE = 31'd1073741824;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_STEPS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_RATIO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_PROBABILITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DISCOUNT  = 3'd4;

    // payoff of one terminal node
    function automatic t_value payoff(input t_value price, input t_value strike,
                                      input logic put);
        t_value res;
        res = '0;
        if (put) begin
            if (strike > price) begin
                res = strike - price;
            end
        end else begin
            if (price > strike) begin
                res = price - strike;
            end
        end
        return res;
    endfunction

endpackage

[rtl/core/binomial_tree_option_pricer.sv]
`timescale 1ns / 1ps
// ============================================================================
// binomial_tree_option_pricer
// Cox-Ross-Rubinstein pricer for one European call or put per request.
// ============================================================================
// Each request (spot, strike, call/put) is priced on a tree of tree_steps
// steps (clamped to MAX_STEPS) and returns one result: the root value in
// Q16.16 and a flag that is set when any price or node value of that request
// was clamped to 2^32-1. Software loads the down factor d, the ratio u/d
// (Q2.30), the up probability p and the per-step discount; d, p and the
// discount are Q1.30 and p above one is used as one. Configuration is to
// be written only while the block is idle; the block itself does not
// enforce this. One request is worked on at a time: spot*d^n is built step
// by step, the lowest terminal node is written straight and each further
// one is scaled by u/d, both products through one shared multiplier, then
// backward induction streams one node a cycle through the node memory (one
// read and one write port; level j reads j+1 nodes), with a pipeline drain
// between tree levels, since each level reads what the level before wrote.
// A new request is taken while the previous result still waits in the
// output register.
// ============================================================================
module binomial_tree_option_pricer
    import btop_pkg::*;
#(
    parameter int MAX_STEPS = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_spot_price,
    input  logic [31:0]          i_strike_price,
    input  logic                 i_is_put,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_option_value,
    output logic                 o_saturated
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int DEPTH  = MAX_STEPS + 1;
    localparam logic [STEP_W-1:0] MAX_N = STEP_W'(MAX_STEPS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DOWN_MUL = 4'd1;
    localparam logic [3:0] S_DOWN_SAT = 4'd2;
    localparam logic [3:0] S_TERM_WR  = 4'd3;
    localparam logic [3:0] S_TERM_MUL = 4'd4;
    localparam logic [3:0] S_TERM_SAT = 4'd5;
    localparam logic [3:0] S_FOLD     = 4'd6;
    localparam logic [3:0] S_DRAIN    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    // configuration registers
    logic [7:0] r_tree_steps;
    t_q30       r_down_factor;
    t_value     r_growth_ratio;
    t_q30       r_up_probability;
    t_q30       r_step_discount;

    // control
    logic [3:0]        r_state;
    logic [STEP_W-1:0] r_n;
    logic [STEP_W-1:0] r_idx;
    logic [STEP_W-1:0] r_row;
    logic [STEP_W-1:0] r_rd_addr;
    logic              r_sat;
    logic              r_rv;
    logic              r_av;
    logic              r_bv;
    logic              r_cv;

    // payload
    t_value            r_strike;
    logic              r_put;
    t_q30              r_p;
    t_q30              r_q;
    t_value            r_price;
    t_value            r_root;
    logic [63:0]       r_prod;
    t_value            r_rd_data;
    logic [STEP_W-1:0] r_rv_addr;
    t_value            r_prev;
    logic [62:0]       r_pu;
    logic [62:0]       r_ql;
    logic [STEP_W-1:0] r_a_addr;
    t_value            r_mix;
    logic [STEP_W-1:0] r_b_addr;
    logic [STEP_W-1:0] r_c_addr;

    logic              r_out_valid;
    t_value            r_out_value;
    logic              r_out_sat;

    // node memory
    t_value r_mem [0:DEPTH-1];

    logic [3:0]        n_state;
    logic [31:0]       steps_ext;
    logic [STEP_W-1:0] n_clamped;
    t_q30              p_clamped;
    logic              in_acc;
    logic              out_load;
    logic              pipe_empty;
    t_value            m_a;
    t_value            m_f;
    t_value            prod_val;
    logic              prod_ovf;
    t_value            term_pay;
    logic              wr_en;
    logic [STEP_W-1:0] wr_addr;
    t_value            wr_data;

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_acc         = i_in_valid && (r_state == S_IDLE);
    assign out_load       = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign pipe_empty     = !r_rv && !r_av && !r_bv && !r_cv;
    assign o_out_valid    = r_out_valid;
    assign o_option_value = r_out_value;
    assign o_saturated    = r_out_sat;

    // clamp the step count and the probability
    assign steps_ext = 32'(r_tree_steps);
    assign n_clamped = (steps_ext > 32'(MAX_STEPS)) ? MAX_N : steps_ext[STEP_W-1:0];
    assign p_clamped = (r_up_probability > Q30_ONE) ? Q30_ONE : r_up_probability;

    // shared multiplier: price scaling, or the discount step of the fold
    always_comb begin
        m_a = r_mix;
        m_f = 32'(r_step_discount);
        unique case (r_state)
            S_DOWN_MUL: begin
                m_a = r_price;
                m_f = 32'(r_down_factor);
            end
            S_TERM_MUL: begin
                m_a = r_price;
                m_f = r_growth_ratio;
            end
            default: begin
                m_a = r_mix;
                m_f = 32'(r_step_discount);
            end
        endcase
    end

    // drop 30 fraction bits, clamp to 32 bits
    assign prod_ovf = |r_prod[63:62];
    assign prod_val = prod_ovf ? '1 : r_prod[61:30];
    assign term_pay = payoff(r_price, r_strike, r_put);

    // memory write: terminal payoffs, then folded node values
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = term_pay;
        if (r_state == S_TERM_WR) begin
            wr_en = 1'b1;
        end else if (r_cv) begin
            wr_en   = 1'b1;
            wr_addr = r_c_addr;
            wr_data = prod_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (n_clamped == '0) ? S_TERM_WR : S_DOWN_MUL;
                end
            end
            S_DOWN_MUL: n_state = S_DOWN_SAT;
            S_DOWN_SAT: begin
                n_state = (r_idx == r_n - 1'b1) ? S_TERM_WR : S_DOWN_MUL;
            end
            S_TERM_WR: begin
                if (r_idx == r_n) begin
                    n_state = (r_n == '0) ? S_DONE : S_FOLD;
                end else begin
                    n_state = S_TERM_MUL;
                end
            end
            S_TERM_MUL: n_state = S_TERM_SAT;
            S_TERM_SAT: n_state = S_TERM_WR;
            S_FOLD: begin
                if (r_rd_addr == r_row) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (pipe_empty) begin
                    n_state = (r_row == 1'b1) ? S_DONE : S_FOLD;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_tree_steps     <= 8'd64;
            r_down_factor    <= Q30_ONE;
            r_growth_ratio   <= 32'(Q30_ONE);
            r_up_probability <= 31'd536870912;
            r_step_discount  <= Q30_ONE;
            r_n              <= '0;
            r_idx            <= '0;
            r_row            <= '0;
            r_rd_addr        <= '0;
            r_sat            <= 1'b0;
            r_rv             <= 1'b0;
            r_av             <= 1'b0;
            r_bv             <= 1'b0;
            r_cv             <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TREE_STEPS:     r_tree_steps     <= i_cfg_data[7:0];
                    CFG_DOWN_FACTOR:    r_down_factor    <= i_cfg_data[30:0];
                    CFG_GROWTH_RATIO:   r_growth_ratio   <= i_cfg_data;
                    CFG_UP_PROBABILITY: r_up_probability <= i_cfg_data[30:0];
                    CFG_STEP_DISCOUNT:  r_step_discount  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            // fold pipeline valids
            r_rv <= (r_state == S_FOLD);
            r_av <= r_rv && (r_rv_addr != '0);
            r_bv <= r_av;
            r_cv <= r_bv;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_n   <= n_clamped;
                        r_idx <= '0;
                        r_sat <= 1'b0;
                    end
                end
                S_DOWN_SAT: begin
                    r_sat <= r_sat | prod_ovf;
                    r_idx <= (r_idx == r_n - 1'b1) ? '0 : r_idx + 1'b1;
                end
                S_TERM_WR: begin
                    if (r_idx == r_n) begin
                        r_row     <= r_n;
                        r_rd_addr <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TERM_SAT: begin
                    r_sat <= r_sat | prod_ovf;
                end
                S_FOLD: begin
                    if (r_rd_addr != r_row) begin
                        r_rd_addr <= r_rd_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // advance to the next level once the last write landed
                    if (pipe_empty && (r_row != 1'b1)) begin
                        r_row     <= r_row - 1'b1;
                        r_rd_addr <= '0;
                    end
                end
                default: ;
            endcase

            if (r_cv) begin
                r_sat <= r_sat | prod_ovf;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, m_a} * {32'd0, m_f};

        if (in_acc) begin
            r_strike <= i_strike_price;
            r_put    <= i_is_put;
            r_price  <= i_spot_price;
            r_p      <= p_clamped;
            r_q      <= Q30_ONE - p_clamped;
        end

        if ((r_state == S_DOWN_SAT) || (r_state == S_TERM_SAT)) begin
            r_price <= prod_val;
        end

        // fold: read stage tag, then p*upper and q*lower, then the mix
        r_rv_addr <= r_rd_addr;
        if (r_rv) begin
            r_prev   <= r_rd_data;
            r_pu     <= {32'd0, r_p} * {31'd0, r_rd_data};
            r_ql     <= {32'd0, r_q} * {31'd0, r_prev};
            r_a_addr <= r_rv_addr - 1'b1;
        end
        r_mix    <= r_pu[61:30] + r_ql[61:30];
        r_b_addr <= r_a_addr;
        r_c_addr <= r_b_addr;

        // hold the value written to the root node
        if (wr_en && (wr_addr == '0)) begin
            r_root <= wr_data;
        end

        if (out_load) begin
            r_out_value <= r_root;
            r_out_sat   <= r_sat;
        end
    end

endmodule
